// ===== rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, codes and constants of the drift PI rate controller.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // Values taken when the matching register holds zero
  localparam logic [30:0] MaxCorrDefault  = 31'd6553600;
  localparam logic [30:0] MaxStepDefault  = 31'd655360;
  localparam logic [31:0] IntervalDefault = 32'd100000;

  localparam logic signed [63:0] Int64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Int64Min = 64'sh8000_0000_0000_0000;

  // Register indexes on the configuration port
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PROP_GAIN       = 3'd0;
  localparam cfg_idx_t CFG_INTEG_GAIN      = 3'd1;
  localparam cfg_idx_t CFG_MAX_CORRECTION  = 3'd2;
  localparam cfg_idx_t CFG_MAX_STEP        = 3'd3;
  localparam cfg_idx_t CFG_DEADBAND        = 3'd4;
  localparam cfg_idx_t CFG_UPDATE_INTERVAL = 3'd5;

  // Request commands
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic signed [31:0] error_us;
    logic [47:0]       now_us;
  } dpc_in_t;

  typedef struct packed {
    logic signed [31:0] correction_ppm;
    logic              updated;
  } dpc_out_t;

  typedef struct packed {
    logic signed [31:0] prop_gain;
    logic signed [31:0] integ_gain;
    logic [30:0]       max_correction;
    logic [30:0]       max_step;
    logic [31:0]       deadband;
    logic [31:0]       update_interval;
  } dpc_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MT0,
    ST_MT1,
    ST_MP,
    ST_SATM,
    ST_ADDI,
    ST_ABSC,
    ST_MI0,
    ST_MI1,
    ST_IW,
    ST_ITERM,
    ST_SUM,
    ST_WIND,
    ST_STEP,
    ST_DONE
  } dpc_state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_START,
    DP_PREP,
    DP_TLAT,
    DP_THI,
    DP_SATM,
    DP_ADDI,
    DP_ABSC,
    DP_IW,
    DP_ITERM,
    DP_SUM,
    DP_WIND,
    DP_STEP
  } dpc_op_e;

  typedef enum logic [2:0] {
    MS_T_LO,
    MS_T_HI,
    MS_PROP,
    MS_I_LO,
    MS_I_HI
  } dpc_mul_sel_e;

  typedef struct packed {
    dpc_op_e      op;
    dpc_mul_sel_e mul_sel;
  } dpc_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic started;
    logic run_ok;
  } dpc_status_t;

endpackage

// ===== rtl/dpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpc_ctrl
// Sequencer of the drift PI controller: steps the datapath through one request.
// ----------------------------------------------------------------------------
module dpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  input  dpc_pkg::dpc_status_t status_i,
  output logic                 in_stall_o,
  output logic                 emit_o,
  output dpc_pkg::dpc_cmd_t    cmd_o
);

  dpc_pkg::dpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = dpc_pkg::DP_NONE;
    cmd_o.mul_sel = dpc_pkg::MS_T_LO;
    in_stall_o    = 1'b1;
    emit_o        = 1'b0;
    unique case (state_q)
      dpc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = dpc_pkg::DP_LOAD;
          state_d  = dpc_pkg::ST_DECIDE;
        end
      end
      dpc_pkg::ST_DECIDE: begin
        priority if (status_i.is_clear) begin
          cmd_o.op = dpc_pkg::DP_CLEAR;
          state_d  = dpc_pkg::ST_DONE;
        end else if (!status_i.started) begin
          cmd_o.op = dpc_pkg::DP_START;
          state_d  = dpc_pkg::ST_DONE;
        end else if (!status_i.run_ok) begin
          state_d = dpc_pkg::ST_DONE;
        end else begin
          cmd_o.op = dpc_pkg::DP_PREP;
          state_d  = dpc_pkg::ST_MT0;
        end
      end
      dpc_pkg::ST_MT0: begin
        cmd_o.mul_sel = dpc_pkg::MS_T_LO;
        state_d       = dpc_pkg::ST_MT1;
      end
      dpc_pkg::ST_MT1: begin
        cmd_o.mul_sel = dpc_pkg::MS_T_HI;
        cmd_o.op      = dpc_pkg::DP_TLAT;
        state_d       = dpc_pkg::ST_MP;
      end
      dpc_pkg::ST_MP: begin
        cmd_o.mul_sel = dpc_pkg::MS_PROP;
        cmd_o.op      = dpc_pkg::DP_THI;
        state_d       = dpc_pkg::ST_SATM;
      end
      dpc_pkg::ST_SATM: begin
        cmd_o.op = dpc_pkg::DP_SATM;
        state_d  = dpc_pkg::ST_ADDI;
      end
      dpc_pkg::ST_ADDI: begin
        cmd_o.op = dpc_pkg::DP_ADDI;
        state_d  = dpc_pkg::ST_ABSC;
      end
      dpc_pkg::ST_ABSC: begin
        cmd_o.op = dpc_pkg::DP_ABSC;
        state_d  = dpc_pkg::ST_MI0;
      end
      dpc_pkg::ST_MI0: begin
        cmd_o.mul_sel = dpc_pkg::MS_I_LO;
        state_d       = dpc_pkg::ST_MI1;
      end
      dpc_pkg::ST_MI1: begin
        cmd_o.mul_sel = dpc_pkg::MS_I_HI;
        cmd_o.op      = dpc_pkg::DP_TLAT;
        state_d       = dpc_pkg::ST_IW;
      end
      dpc_pkg::ST_IW: begin
        cmd_o.op = dpc_pkg::DP_IW;
        state_d  = dpc_pkg::ST_ITERM;
      end
      dpc_pkg::ST_ITERM: begin
        cmd_o.op = dpc_pkg::DP_ITERM;
        state_d  = dpc_pkg::ST_SUM;
      end
      dpc_pkg::ST_SUM: begin
        cmd_o.op = dpc_pkg::DP_SUM;
        state_d  = dpc_pkg::ST_WIND;
      end
      dpc_pkg::ST_WIND: begin
        cmd_o.op = dpc_pkg::DP_WIND;
        state_d  = dpc_pkg::ST_STEP;
      end
      dpc_pkg::ST_STEP: begin
        cmd_o.op = dpc_pkg::DP_STEP;
        state_d  = dpc_pkg::ST_DONE;
      end
      dpc_pkg::ST_DONE: begin
        if (out_free_i) begin
          emit_o  = 1'b1;
          state_d = dpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/dpc_dp.sv =====
// ----------------------------------------------------------------------------
// dpc_dp
// Datapath of the drift PI controller: controller state, one shared 32x32
// multiplier and the saturation, anti-windup, clamp and slew logic.
// ----------------------------------------------------------------------------
module dpc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dpc_pkg::dpc_cmd_t    cmd_i,
  input  dpc_pkg::dpc_in_t     in_data_i,
  input  dpc_pkg::dpc_cfg_t    cfg_i,
  output dpc_pkg::dpc_status_t status_o,
  output logic signed [31:0]   corr_o,
  output logic                 ran_o
);

  // Controller state
  logic signed [63:0] acc_q;
  logic signed [31:0] corr_q;
  logic [47:0]        last_q;
  logic               started_q;
  logic               ran_q;

  // Working registers
  logic [47:0]        now_q;
  logic signed [31:0] err_q;
  logic               clear_q;
  logic [48:0]        elapsed_q;
  logic [31:0]        emag_q, pgmag_q, igmag_q;
  logic               e_pos_q, e_neg_q;
  logic [63:0]        prod_q, t0_q;
  logic [48:0]        hi_q;
  logic [62:0]        pp_q;
  logic signed [63:0] sm_q, cand_q;
  logic [63:0]        cmag_q;
  logic signed [47:0] pterm_q;
  logic [55:0]        iq_q;
  logic               irem_q;
  logic signed [57:0] iterm_q, wanted_q;
  logic signed [31:0] clamp_q;

  // Effective limits
  logic [30:0] maxc, step_raw, step;
  logic [31:0] interval;
  logic        run_ok;

  assign maxc     = (cfg_i.max_correction == '0) ? dpc_pkg::MaxCorrDefault
                                                 : cfg_i.max_correction;
  assign step_raw = (cfg_i.max_step == '0) ? dpc_pkg::MaxStepDefault : cfg_i.max_step;
  assign step     = (step_raw > maxc) ? maxc : step_raw;
  assign interval = (cfg_i.update_interval == '0) ? dpc_pkg::IntervalDefault
                                                  : cfg_i.update_interval;
  assign run_ok   = !elapsed_q[48] && (elapsed_q[47:0] >= {16'b0, interval});

  // Error preparation: deadband, magnitude, sign of e = -error
  logic [31:0] err_abs, pg_abs, ig_abs;
  logic        dead;

  assign err_abs = err_q[31] ? 32'(-err_q) : 32'(err_q);
  assign pg_abs  = cfg_i.prop_gain[31] ? 32'(-cfg_i.prop_gain) : 32'(cfg_i.prop_gain);
  assign ig_abs  = cfg_i.integ_gain[31] ? 32'(-cfg_i.integ_gain) : 32'(cfg_i.integ_gain);
  assign dead    = err_abs <= cfg_i.deadband;

  // Shared multiplier, operands are magnitudes
  logic [31:0] mul_a, mul_b;

  always_comb begin
    unique case (cmd_i.mul_sel)
      dpc_pkg::MS_T_LO: begin
        mul_a = emag_q;
        mul_b = elapsed_q[31:0];
      end
      dpc_pkg::MS_T_HI: begin
        mul_a = emag_q;
        mul_b = {16'b0, elapsed_q[47:32]};
      end
      dpc_pkg::MS_PROP: begin
        mul_a = pgmag_q;
        mul_b = emag_q;
      end
      dpc_pkg::MS_I_LO: begin
        mul_a = igmag_q;
        mul_b = cmag_q[31:0];
      end
      dpc_pkg::MS_I_HI: begin
        mul_a = igmag_q;
        mul_b = cmag_q[63:32];
      end
      default: begin
        mul_a = emag_q;
        mul_b = elapsed_q[31:0];
      end
    endcase
  end

  // e * elapsed saturated to 64 bits; hi_q holds bits 80..32 of the product
  logic [63:0]        pmag;
  logic signed [63:0] sm_d;

  assign pmag = {hi_q[31:0], t0_q[31:0]};

  always_comb begin
    priority if (e_pos_q) begin
      sm_d = (hi_q >= 49'h0_8000_0000) ? dpc_pkg::Int64Max : $signed(pmag);
    end else if (e_neg_q) begin
      sm_d = ((hi_q > 49'h0_8000_0000) ||
              (hi_q == 49'h0_8000_0000 && t0_q[31:0] != '0)) ? dpc_pkg::Int64Min
                                                             : -$signed(pmag);
    end else begin
      sm_d = $signed(pmag);
    end
  end

  // Saturating integral add
  logic [64:0]        sum_ext;
  logic signed [63:0] cand_d;

  assign sum_ext = {acc_q[63], acc_q} + {sm_q[63], sm_q};
  assign cand_d  = (sum_ext[64] != sum_ext[63])
                 ? (sum_ext[64] ? dpc_pkg::Int64Min : dpc_pkg::Int64Max)
                 : $signed(sum_ext[63:0]);

  // P term: floor(kp * e / 2^16)
  logic [47:0]        pq, pround;
  logic               pneg;
  logic signed [47:0] pterm_d;

  assign pq      = {1'b0, pp_q[62:16]};
  assign pround  = pq + 48'(pp_q[15:0] != '0);
  assign pneg    = (cfg_i.prop_gain[31] ^ e_neg_q) && (pgmag_q != '0) && (emag_q != '0);
  assign pterm_d = pneg ? -$signed(pround) : $signed(pq);

  // I term: floor(ki * acc / 2^40)
  logic [63:0]        mid;
  logic [57:0]        imag;
  logic               ineg;
  logic signed [57:0] iterm_d;

  assign mid     = prod_q + {32'b0, t0_q[63:32]};
  assign imag    = {2'b0, iq_q} + 58'(irem_q);
  assign ineg    = (cfg_i.integ_gain[31] != cand_q[63]) && (igmag_q != '0) && (cmag_q != '0);
  assign iterm_d = ineg ? -$signed(imag) : $signed({2'b0, iq_q});

  // Anti-windup and clamp
  logic signed [57:0] maxc_pos, maxc_neg;
  logic               in_range, keep;
  logic signed [31:0] clamp_d;

  assign maxc_pos = $signed({27'b0, maxc});
  assign maxc_neg = -maxc_pos;
  assign in_range = (wanted_q <= maxc_pos) && (wanted_q >= maxc_neg);
  assign keep     = in_range || (wanted_q[57] && e_pos_q) ||
                    (!wanted_q[57] && wanted_q != '0 && e_neg_q);
  assign clamp_d  = in_range ? wanted_q[31:0]
                             : (wanted_q[57] ? maxc_neg[31:0] : maxc_pos[31:0]);

  // Slew limit
  logic signed [33:0] corr_ext, clamp_ext, step_ext, up, dn;
  logic signed [31:0] corr_d;

  assign corr_ext  = {{2{corr_q[31]}}, corr_q};
  assign clamp_ext = {{2{clamp_q[31]}}, clamp_q};
  assign step_ext  = $signed({3'b0, step});
  assign up        = corr_ext + step_ext;
  assign dn        = corr_ext - step_ext;
  assign corr_d    = (clamp_ext > up) ? up[31:0] : ((clamp_ext < dn) ? dn[31:0] : clamp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      corr_q    <= '0;
      last_q    <= '0;
      started_q <= 1'b0;
      ran_q     <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        dpc_pkg::DP_LOAD: begin
          ran_q <= 1'b0;
        end
        dpc_pkg::DP_CLEAR: begin
          acc_q     <= '0;
          corr_q    <= '0;
          last_q    <= '0;
          started_q <= 1'b0;
        end
        dpc_pkg::DP_START: begin
          last_q    <= now_q;
          started_q <= 1'b1;
        end
        dpc_pkg::DP_PREP: begin
          last_q <= now_q;
          ran_q  <= 1'b1;
        end
        dpc_pkg::DP_WIND: begin
          if (keep) begin
            acc_q <= cand_q;
          end
        end
        dpc_pkg::DP_STEP: begin
          corr_q <= corr_d;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      dpc_pkg::DP_LOAD: begin
        now_q     <= in_data_i.now_us;
        err_q     <= in_data_i.error_us;
        clear_q   <= in_data_i.cmd == dpc_pkg::CMD_CLEAR;
        elapsed_q <= {1'b0, in_data_i.now_us} - {1'b0, last_q};
      end
      dpc_pkg::DP_PREP: begin
        emag_q  <= dead ? '0 : err_abs;
        e_pos_q <= !dead && err_q[31];
        e_neg_q <= !dead && !err_q[31];
        pgmag_q <= pg_abs;
        igmag_q <= ig_abs;
      end
      dpc_pkg::DP_TLAT: begin
        t0_q <= prod_q;
      end
      dpc_pkg::DP_THI: begin
        hi_q <= {1'b0, prod_q[47:0]} + {17'b0, t0_q[63:32]};
      end
      dpc_pkg::DP_SATM: begin
        sm_q <= sm_d;
        pp_q <= prod_q[62:0];
      end
      dpc_pkg::DP_ADDI: begin
        cand_q  <= cand_d;
        pterm_q <= pterm_d;
      end
      dpc_pkg::DP_ABSC: begin
        cmag_q <= cand_q[63] ? 64'(-cand_q) : 64'(cand_q);
      end
      dpc_pkg::DP_IW: begin
        iq_q   <= mid[63:8];
        irem_q <= (mid[7:0] != '0) || (t0_q[31:0] != '0);
      end
      dpc_pkg::DP_ITERM: begin
        iterm_q <= iterm_d;
      end
      dpc_pkg::DP_SUM: begin
        wanted_q <= $signed({{10{pterm_q[47]}}, pterm_q}) + iterm_q;
      end
      dpc_pkg::DP_WIND: begin
        clamp_q <= clamp_d;
      end
      default: begin
      end
    endcase
  end

  assign status_o.is_clear = clear_q;
  assign status_o.started  = started_q;
  assign status_o.run_ok   = run_ok;
  assign corr_o            = corr_q;
  assign ran_o             = ran_q;

endmodule

// ===== rtl/drift_pi_controller.sv =====
// ----------------------------------------------------------------------------
// drift_pi_controller
// PI rate controller with anti-windup and slew limit, Q16.16 ppm output.
// Requests enter on in_valid_i / in_stall_o; one result per request leaves on
// out_valid_o / out_stall_i. Registers are written on cfg_valid_i / cfg_ready_o
// (always ready); the user must write them only while no request is in flight,
// which the block itself does not enforce. A control-law run passes five
// 32x32 products (error x elapsed twice, P term, I term twice) through one
// shared multiplier and then saturates, clamps and slews in single steps; a
// clear, a first timestamp or a too-early request skips all of that. The next
// request is taken the cycle after the result is loaded.
// Reset clears integral, correction, last time and started flag and loads the
// register defaults. If the receiver stalls, the result waits in the output
// register; a new request is still accepted but its result is held back in the
// final step until the output register frees up.
// ----------------------------------------------------------------------------
module drift_pi_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dpc_pkg::dpc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dpc_pkg::dpc_out_t  out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  dpc_pkg::cfg_idx_t  cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  dpc_pkg::dpc_cfg_t    cfg_q;
  dpc_pkg::dpc_cmd_t    dp_cmd;
  dpc_pkg::dpc_status_t dp_status;
  logic signed [31:0]   dp_corr;
  logic                 dp_ran;
  logic                 emit;
  logic                 out_free;
  logic                 out_valid_q;
  dpc_pkg::dpc_out_t    out_data_q;

  // Register file; writes are never held off
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= '0;
      cfg_q.integ_gain      <= '0;
      cfg_q.max_correction  <= dpc_pkg::MaxCorrDefault;
      cfg_q.max_step        <= dpc_pkg::MaxStepDefault;
      cfg_q.deadband        <= '0;
      cfg_q.update_interval <= dpc_pkg::IntervalDefault;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dpc_pkg::CFG_PROP_GAIN:       cfg_q.prop_gain       <= cfg_data_i;
        dpc_pkg::CFG_INTEG_GAIN:      cfg_q.integ_gain      <= cfg_data_i;
        dpc_pkg::CFG_MAX_CORRECTION:  cfg_q.max_correction  <= cfg_data_i[30:0];
        dpc_pkg::CFG_MAX_STEP:        cfg_q.max_step        <= cfg_data_i[30:0];
        dpc_pkg::CFG_DEADBAND:        cfg_q.deadband        <= cfg_data_i;
        dpc_pkg::CFG_UPDATE_INTERVAL: cfg_q.update_interval <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Output register frees up when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  dpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (dp_status),
    .in_stall_o (in_stall_o),
    .emit_o     (emit),
    .cmd_o      (dp_cmd)
  );

  dpc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (dp_cmd),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .status_o  (dp_status),
    .corr_o    (dp_corr),
    .ran_o     (dp_ran)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.correction_ppm <= dp_corr;
      out_data_q.updated        <= dp_ran;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A request being taken puts the sequencer to work on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted but sequencer not busy");

  // A new result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !(out_valid_q && out_stall_i))
    else $error("result overwritten while stalled");

  // Without a control-law run the correction is unchanged, or zero after clear
  a_hold_corr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !dp_ran |-> (dp_corr == '0 || $stable(dp_corr)))
    else $error("correction moved without a control-law run");

endmodule
